/* design/bdq_pkg.sv */
// Shared types and constants for the bounded deque unit.
// No dependencies; every other design file refers to this package by scope.
`default_nettype none

package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int CNT_W         = 5;   // capacity and occupancy width
  localparam int DEPTH_DEFAULT = 16;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // capture request fields
    logic exec;   // apply request to storage and pointers
  } cmd_t;

endpackage

`default_nettype wire

/* design/bdq_ctrl.sv */
// Sequencer for the bounded deque: accept, execute, present result.
// Depends on bdq_pkg (cmd_t).
`default_nettype none

module bdq_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  output logic             out_valid,
  output bdq_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;
  logic   accept;

  assign accept = start && !busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_RESP;
      S_RESP:  state_nxt = accept ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt == S_EXEC);
      out_valid_r <= (state_nxt == S_RESP);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

`default_nettype wire

/* design/bdq_dpath.sv */
// Datapath of the bounded deque: slot memory, head pointer, count, capacity.
// Depends on bdq_pkg (widths, kind/status codes, cmd_t).
`default_nettype none

module bdq_dpath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bdq_pkg::cmd_t                   cmd,
  input  wire logic [1:0]                      in_kind,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] in_value,
  input  wire logic                            cfg_we,
  input  wire logic [bdq_pkg::CNT_W-1:0]       cfg_capacity,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_popped_value,
  output logic [1:0]                           out_status,
  output logic [bdq_pkg::CNT_W-1:0]            out_occupancy
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CapMax = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [bdq_pkg::CNT_W-1:0] CAP_MAX = bdq_pkg::CNT_W'(CapMax);
  localparam logic [PTR_W:0]   DEPTH_X = (PTR_W+1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);

  logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];

  bdq_pkg::kind_t              kind_r;
  logic [bdq_pkg::DATA_W-1:0]  value_r;
  logic [PTR_W-1:0]            head_r, head_nxt;
  logic [bdq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [bdq_pkg::CNT_W-1:0]   cap_r;
  bdq_pkg::status_t            status_r, status_nxt;
  logic [bdq_pkg::CNT_W-1:0]   occ_r;
  logic                        pop_ok_r, pop_ok_nxt;
  logic [bdq_pkg::DATA_W-1:0]  rd_data_r;

  logic [bdq_pkg::CNT_W-1:0]   eff_cap;
  logic                        is_full, is_empty;
  logic [PTR_W-1:0]            addr, head_inc, head_dec;
  logic [bdq_pkg::CNT_W-1:0]   count_m1;
  logic                        wr_en;

  // base + off modulo DEPTH, both operands below DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W:0] base,
                                                input logic [PTR_W:0] off);
    logic [PTR_W:0] sum;
    sum = base + off;
    if (sum >= DEPTH_X) sum = sum - DEPTH_X;
    return sum[PTR_W-1:0];
  endfunction

  assign eff_cap  = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign is_full  = (count_r >= eff_cap);
  assign is_empty = (count_r == '0);
  assign count_m1 = count_r - 1'b1;
  assign head_inc = wrap_add({1'b0, head_r}, (PTR_W+1)'(1));
  assign head_dec = (head_r == '0) ? LAST : head_r - 1'b1;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = bdq_pkg::ST_OK;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    addr       = head_r;
    unique case (kind_r)
      bdq_pkg::KIND_PUSH_BACK: begin
        addr = wrap_add({1'b0, head_r}, (PTR_W+1)'(count_r));
        if (is_full) begin
          status_nxt = bdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      bdq_pkg::KIND_PUSH_FRONT: begin
        addr = head_dec;
        if (is_full) begin
          status_nxt = bdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      bdq_pkg::KIND_POP_FRONT: begin
        addr = head_r;
        if (is_empty) begin
          status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          pop_ok_nxt = 1'b1;
          head_nxt   = head_inc;
          count_nxt  = count_m1;
        end
      end
      bdq_pkg::KIND_POP_BACK: begin
        addr = wrap_add({1'b0, head_r}, (PTR_W+1)'(count_m1));
        if (is_empty) begin
          status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          pop_ok_nxt = 1'b1;
          count_nxt  = count_m1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      cap_r   <= bdq_pkg::CAP_RESET;
    end else begin
      if (cfg_we) cap_r <= cfg_capacity;
      if (cmd.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // request fields and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= bdq_pkg::kind_t'(in_kind);
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      occ_r    <= count_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  // slot memory, one access per request, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) mem[addr] <= value_r;
      rd_data_r <= mem[addr];
    end
  end

  assign out_popped_value = pop_ok_r ? $signed(rd_data_r) : '0;
  assign out_status       = status_r;
  assign out_occupancy    = occ_r;

endmodule

`default_nettype wire

/* design/bounded_deque_unit.sv */
// Top level of the bounded deque unit: sequencer plus datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_dpath.
`default_nettype none

// Bounded double-ended queue of signed 32-bit words.
//
// Request channel: a transaction is taken on a rising edge with start high
// and busy low. in_kind selects push back, push front, pop front or pop back;
// in_value is the word to push and is ignored for pops.
// Result channel: every request yields exactly one result, shown for one
// cycle with out_valid high: popped word (zero unless a pop succeeded),
// status (ok, full/push refused, empty/pop refused) and occupancy after the
// request. The receiver cannot stall; results must be taken when shown.
// Config channel: cfg_capacity is written when cfg_valid is high (cfg_ready
// is always high). Values above DEPTH act as DEPTH. Write only while idle.
//
// Timing: a request accepted at an edge is executed in the following cycle
// and its result is shown in the cycle after that. busy is high for the
// execute cycle only, so a new request can be accepted while the previous
// result is on the ports. The popped word comes from the single-port slot
// memory, whose registered read is taken in the execute cycle.
//
// Reset (rst_n low, synchronous): deque emptied, head pointer at zero,
// capacity back to 16, no result pending. Slot contents are not cleared.
module bounded_deque_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_kind,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                                   out_valid,
  output logic signed [bdq_pkg::DATA_W-1:0]      out_popped_value,
  output logic [1:0]                             out_status,
  output logic [bdq_pkg::CNT_W-1:0]              out_occupancy,
  // capacity register write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bdq_pkg::CNT_W-1:0]         cfg_capacity
);

  bdq_pkg::cmd_t cmd;

  // capacity register is always writable
  assign cfg_ready = 1'b1;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_capacity     (cfg_capacity),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

endmodule

`default_nettype wire

/* design/bdq_checker.sv */
// Port-level checks for the bounded deque unit, bound to the top level.
// Depends on bdq_pkg (status codes) and bounded_deque_unit.
`default_nettype none

module bdq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_popped_value,
  input wire logic [1:0]  out_status
);

  // accepted transaction occupies the execute cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // execute cycle is always followed by exactly one result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("no result after execute cycle");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bdq_pkg::ST_OK || out_status == bdq_pkg::ST_FULL ||
                   out_status == bdq_pkg::ST_EMPTY))
    else $error("illegal status code");

  // refused request never carries data
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bdq_pkg::ST_OK) |-> (out_popped_value == '0))
    else $error("refused request returned nonzero data");

endmodule

bind bounded_deque_unit bdq_checker u_bdq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_popped_value (out_popped_value),
  .out_status       (out_status)
);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for bounded_deque_unit: directed corner requests, then
// random push/pop traffic across capacity settings and idle patterns.
// Depends on bdq_pkg and the bounded_deque_unit RTL.
`timescale 1ns / 1ps

module tb;
  import bdq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 119;

  // One expected result of a request.
  typedef struct {
    logic [DATA_W-1:0] popped;
    status_t           status;
    logic [CNT_W-1:0]  occupancy;
  } deque_result_t;

  // Shadow deque: tracks the storage, head pointer, count and capacity, and
  // queues the result that each accepted request must produce.
  class deque_tracker;
    logic [DATA_W-1:0] slot_mem [DEPTH];
    int                head;
    int                count;
    logic [CNT_W-1:0]  cap_reg;
    deque_result_t     pending_results[$];
    int                failures;
    int                mismatches;

    function new();
      head = 0;
      count = 0;
      cap_reg = CAP_RESET;
      failures = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_capacity(logic [CNT_W-1:0] cap);
      cap_reg = cap;
    endfunction

    function void note_request(kind_t kind, logic [DATA_W-1:0] word);
      deque_result_t res;
      int            limit;
      limit = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
      res.popped = '0;
      res.status = ST_OK;
      case (kind)
        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
          if (count >= limit) begin
            res.status = ST_FULL;
          end else if (kind == KIND_PUSH_BACK) begin
            slot_mem[(head + count) % DEPTH] = word;
            count++;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slot_mem[head] = word;
            count++;
          end
        end
        default: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (kind == KIND_POP_FRONT) begin
            res.popped = slot_mem[head];
            head = (head + 1) % DEPTH;
            count--;
          end else begin
            res.popped = slot_mem[(head + count - 1) % DEPTH];
            count--;
          end
        end
      endcase
      res.occupancy = count[CNT_W-1:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] popped, logic [1:0] status,
                               logic [CNT_W-1:0] occupancy);
      deque_result_t exp_res;
      if (pending_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: popped=%h status=%0d occ=%0d",
                   $realtime, popped, status, occupancy);
        return;
      end
      exp_res = pending_results.pop_front();
      if (popped !== exp_res.popped || status !== exp_res.status ||
          occupancy !== exp_res.occupancy) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch exp/got: popped %h/%h status %0d/%0d occ %0d/%0d",
                   $realtime, exp_res.popped, popped, exp_res.status, status,
                   exp_res.occupancy, occupancy);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_kind = KIND_PUSH_BACK;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_popped_value;
  logic [1:0]               out_status;
  logic [CNT_W-1:0]         out_occupancy;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_capacity = '0;

  deque_tracker tracker = new();
  int unsigned  cycle_count = 0;

  bounded_deque_unit #(.DEPTH(DEPTH)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_popped_value(out_popped_value),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity)
  );

  // 10 ns clock: rising edges at 5, 15, ...; stimulus moves on falling edges.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere (lost result, stuck busy) ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL bounded_deque_unit");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, before the RTL's
  // nonblocking updates land, so the values seen are the ones the edge took.
  // Request transactions feed the shadow deque, config writes update its
  // capacity, and every out_valid cycle is checked against the oldest
  // outstanding expectation (the receiver cannot stall, so each strobe is
  // exactly one result).
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        tracker.note_request(kind_t'(in_kind), in_value);
      if (cfg_valid && cfg_ready)
        tracker.set_capacity(cfg_capacity);
      if (out_valid)
        tracker.check_result(out_popped_value, out_status, out_occupancy);
    end
  end

  // Presents one request and holds it until a rising edge sees busy low.
  // Returns on the falling edge after the transaction with start still high,
  // so a back-to-back caller just overwrites the fields.
  task automatic send_request(input kind_t kind, input logic [DATA_W-1:0] word);
    logic taken;
    start <= 1'b1;
    in_kind <= kind;
    in_value <= word;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  // Random sender idling: each cycle idles with probability pct percent.
  task automatic sender_idle(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Drop start and wait until every request has produced its result, plus a
  // short margin so the unit is fully quiet.
  task automatic wait_quiet();
    start <= 1'b0;
    while (tracker.pending() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Capacity is only changed with the unit idle.
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    logic taken;
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0]  phase_caps [PHASES];
    int                idle_pcts [3];
    int                push_bias;
    int                trend_left;
    kind_t             kind;
    logic [DATA_W-1:0] word;

    // Capacity sequence: zero first while the deque is full (capacity below
    // occupancy), then the top of range, one, all ones (saturates to DEPTH),
    // a mid value, just above DEPTH, just below DEPTH, and a random pick.
    phase_caps = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd7, 5'd17, 5'd15, 5'd0};
    phase_caps[PHASES-1] = CNT_W'($urandom_range(31));
    // Sender idle percentages: none, heavy, both-sides rate (sender only here).
    idle_pcts = '{0, 54, 34};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset capacity: pops on an empty deque, extreme words
    // through both ends, then fill to DEPTH and push past it at both ends.
    send_request(KIND_POP_FRONT, 32'h0000_0000);
    send_request(KIND_POP_BACK, 32'hFFFF_FFFF);
    send_request(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(KIND_PUSH_FRONT, 32'h8000_0000);
    send_request(KIND_POP_BACK, 32'h0000_0000);
    send_request(KIND_POP_FRONT, 32'h0000_0000);
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0)
        word = '0;
      else if (i == 1)
        word = '1;
      else
        word = $urandom;
      send_request((i % 2 == 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, word);
    end
    send_request(KIND_PUSH_BACK, 32'h1234_5678);
    send_request(KIND_PUSH_FRONT, 32'h8765_4321);

    // Random phases. The deque state carries over between phases, so a lower
    // capacity often lands on a fuller deque. Push/pop bias swings in runs so
    // the deque keeps travelling between empty and full.
    push_bias = 75;
    trend_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (trend_left == 0) begin
          push_bias = (push_bias > 50) ? 25 : 75;
          trend_left = $urandom_range(30, 8);
        end
        trend_left--;
        if ($urandom_range(99) < push_bias)
          kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        else
          kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        // Mostly random words, sometimes the signed extremes and zero.
        case ($urandom_range(15))
          0:       word = 32'h7FFF_FFFF;
          1:       word = 32'h8000_0000;
          2:       word = '0;
          3:       word = '1;
          default: word = $urandom;
        endcase
        sender_idle(idle_pcts[p % 3]);
        send_request(kind, word);
      end
    end

    wait_quiet();
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("PASS bounded_deque_unit");
    else
      $display("FAIL bounded_deque_unit");
    $finish;
  end

endmodule
